@@ hdl/rgb_image_correlation_macros.svh @@
// Assertion macros for the correlation block checker.
`ifndef RGB_IMAGE_CORRELATION_MACROS_SVH
`define RGB_IMAGE_CORRELATION_MACROS_SVH

// Implication in the same cycle.
`define RIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication on the next cycle.
`define RIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ric_pkg.sv @@
// ----------------------------------------------------------------------------
// ric_pkg
// Types and constants shared by the RGB correlation block.
// ----------------------------------------------------------------------------
package ric_pkg;

  localparam int unsigned MaxPixels = 262144;
  localparam int unsigned CntW      = 19;
  localparam int unsigned FracBits  = 14;
  localparam int unsigned QW        = FracBits + 1;
  localparam int unsigned SumW      = 26;
  localparam int unsigned SqW       = 34;
  localparam int unsigned MulW      = 52;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned CandW     = ProdW + 2 * FracBits + 4;
  localparam int unsigned MulCntW   = 6;
  localparam int unsigned StepW     = 4;
  localparam int unsigned OpW       = 3;
  localparam int unsigned Recip3    = 43691;   // ceil(2^17 / 3)
  localparam int unsigned Recip3Sh  = 17;

  typedef enum logic [OpW-1:0] {
    OpNSxx  = 3'd0,
    OpSxSx  = 3'd1,
    OpNSyy  = 3'd2,
    OpSySy  = 3'd3,
    OpNSxy  = 3'd4,
    OpSxSy  = 3'd5,
    OpVxVy  = 3'd6,
    OpMagSq = 3'd7
  } mul_op_e;

  typedef enum logic [1:0] {
    LnIdle   = 2'd0,
    LnMul    = 2'd1,
    LnSearch = 2'd2,
    LnDone   = 2'd3
  } lane_st_e;

  typedef struct packed {
    logic [7:0] ref_red;
    logic [7:0] ref_green;
    logic [7:0] ref_blue;
    logic [7:0] sample_red;
    logic [7:0] sample_green;
    logic [7:0] sample_blue;
    logic       last_pixel;
  } pix_word_t;

  typedef struct packed {
    logic signed [15:0] corr_red;
    logic signed [15:0] corr_green;
    logic signed [15:0] corr_blue;
    logic signed [15:0] corr_mean;
    logic               defined;
  } corr_word_t;

  typedef struct packed {
    logic          neg;
    logic [QW-1:0] mag;
    logic          zero_var;
  } lane_res_t;

endpackage

@@ hdl/ric_lane.sv @@
// ----------------------------------------------------------------------------
// ric_lane
// One color channel: sums, shift-add multiplier, bitwise ratio search.
// ----------------------------------------------------------------------------
module ric_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     acc_en_i,
  input  logic [7:0]               x_i,
  input  logic [7:0]               y_i,
  input  logic [ric_pkg::CntW-1:0] n_i,
  input  logic                     go_i,
  output logic                     done_o,
  output ric_pkg::lane_res_t       res_o
);
  import ric_pkg::*;

  lane_st_e st_q, st_d;

  logic [SumW-1:0]  sx_q, sy_q;
  logic [SqW-1:0]   sxy_q, sxx_q, syy_q;

  logic [OpW-1:0]     op_q;
  logic [MulCntW-1:0] mcnt_q;
  logic [ProdW-1:0]   mc_q, acc_q;
  logic [MulW-1:0]    mp_q;
  logic [ProdW-1:0]   prod_fin;
  logic [MulW-1:0]    prod_lo;

  logic [MulW-1:0]  t_q, vx_q, vy_q, mag_q;
  logic             neg_q;
  logic [ProdW-1:0] d_q;

  logic [CandW-1:0] p_q, a_q, b_q, tt_q, cand;
  logic [StepW-1:0] k_q;
  logic [QW-1:0]    q_q;

  logic [OpW-1:0] sel;
  logic [MulW-1:0] opa, opb;
  logic mul_last, srch_last;

  assign mul_last  = (mcnt_q == MulCntW'(MulW - 1));
  assign srch_last = (k_q == '0);
  assign prod_fin  = acc_q + (mp_q[0] ? mc_q : '0);
  assign prod_lo   = prod_fin[MulW-1:0];
  assign cand      = p_q + a_q + b_q;

  // Operands of the next product
  assign sel = go_i ? OpW'(OpNSxx) : OpW'(op_q + 1'b1);
  always_comb begin
    opa = '0;
    opb = '0;
    case (mul_op_e'(sel))
      OpNSxx:  begin opa = MulW'(n_i);  opb = MulW'(sxx_q); end
      OpSxSx:  begin opa = MulW'(sx_q); opb = MulW'(sx_q);  end
      OpNSyy:  begin opa = MulW'(n_i);  opb = MulW'(syy_q); end
      OpSySy:  begin opa = MulW'(sy_q); opb = MulW'(sy_q);  end
      OpNSxy:  begin opa = MulW'(n_i);  opb = MulW'(sxy_q); end
      OpSxSy:  begin opa = MulW'(sx_q); opb = MulW'(sy_q);  end
      OpVxVy:  begin opa = vx_q;        opb = vy_q;         end
      OpMagSq: begin opa = mag_q;       opb = mag_q;        end
      default: begin opa = '0;          opb = '0;           end
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      LnIdle:   if (go_i) st_d = LnMul;
      LnMul:    if (mul_last && op_q == OpW'(OpMagSq)) st_d = LnSearch;
      LnSearch: if (srch_last) st_d = LnDone;
      LnDone:   st_d = LnIdle;
      default:  st_d = LnIdle;
    endcase
  end

  always_comb begin
    done_o = (st_q == LnDone);
    res_o.neg      = neg_q;
    res_o.mag      = q_q;
    res_o.zero_var = (vx_q == '0) || (vy_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= LnIdle;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == LnDone) begin
        sx_q  <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
        sxx_q <= '0;
        syy_q <= '0;
      end else if (acc_en_i) begin
        sx_q  <= sx_q + SumW'(x_i);
        sy_q  <= sy_q + SumW'(y_i);
        sxy_q <= sxy_q + SqW'({8'd0, x_i} * {8'd0, y_i});
        sxx_q <= sxx_q + SqW'({8'd0, x_i} * {8'd0, x_i});
        syy_q <= syy_q + SqW'({8'd0, y_i} * {8'd0, y_i});
      end
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (go_i || (st_q == LnMul && mul_last && op_q != OpW'(OpMagSq))) begin
      op_q   <= sel;
      mcnt_q <= '0;
      acc_q  <= '0;
      mc_q   <= ProdW'(opa);
      mp_q   <= opb;
    end else if (st_q == LnMul) begin
      acc_q  <= prod_fin;
      mc_q   <= mc_q << 1;
      mp_q   <= mp_q >> 1;
      mcnt_q <= mcnt_q + 1'b1;
    end

    if (st_q == LnMul && mul_last) begin
      case (mul_op_e'(op_q))
        OpNSxx, OpNSyy, OpNSxy: t_q <= prod_lo;
        OpSxSx:  vx_q <= t_q - prod_lo;
        OpSySy:  vy_q <= t_q - prod_lo;
        OpSxSy: begin
          neg_q <= (t_q < prod_lo);
          mag_q <= (t_q < prod_lo) ? (prod_lo - t_q) : (t_q - prod_lo);
        end
        OpVxVy:  d_q <= prod_fin;
        OpMagSq: begin
          tt_q <= CandW'(prod_fin) << (2 * FracBits);
          b_q  <= CandW'(d_q) << (2 * FracBits);
          a_q  <= '0;
          p_q  <= '0;
          q_q  <= '0;
          k_q  <= StepW'(FracBits);
        end
        default: t_q <= t_q;
      endcase
    end

    // One quotient bit per cycle: test (q + 2^k)^2 * D <= T
    if (st_q == LnSearch) begin
      if (cand <= tt_q) begin
        p_q    <= cand;
        a_q    <= (a_q + (b_q << 1)) >> 1;
        q_q[k_q] <= 1'b1;
      end else begin
        a_q <= a_q >> 1;
      end
      b_q <= b_q >> 2;
      k_q <= k_q - 1'b1;
    end
  end

endmodule

@@ hdl/ric_merge.sv @@
// ----------------------------------------------------------------------------
// ric_merge
// Combines the three lane results into signed words and their mean.
// ----------------------------------------------------------------------------
module ric_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic                  over_i,
  input  ric_pkg::lane_res_t    red_i,
  input  ric_pkg::lane_res_t    green_i,
  input  ric_pkg::lane_res_t    blue_i,
  output logic                  valid_o,
  output ric_pkg::corr_word_t   corr_o
);
  import ric_pkg::*;

  logic               ok;
  logic signed [15:0] qr, qg, qb;
  logic signed [16:0] sum;
  logic [15:0]        sum_mag;
  logic [32:0]        scaled;
  logic [15:0]        mean_mag;
  logic               valid_q;
  corr_word_t         corr_q;

  assign ok = !over_i && !red_i.zero_var && !green_i.zero_var && !blue_i.zero_var;

  always_comb begin
    qr = red_i.neg   ? -$signed(16'(red_i.mag))   : $signed(16'(red_i.mag));
    qg = green_i.neg ? -$signed(16'(green_i.mag)) : $signed(16'(green_i.mag));
    qb = blue_i.neg  ? -$signed(16'(blue_i.mag))  : $signed(16'(blue_i.mag));
    if (!ok) begin
      qr = '0;
      qg = '0;
      qb = '0;
    end
    sum      = 17'(qr) + 17'(qg) + 17'(qb);
    sum_mag  = sum[16] ? 16'(-sum) : 16'(sum);
    scaled   = 33'(sum_mag) * 33'(Recip3);
    mean_mag = 16'(scaled >> Recip3Sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= go_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      corr_q.corr_red   <= qr;
      corr_q.corr_green <= qg;
      corr_q.corr_blue  <= qb;
      corr_q.corr_mean  <= sum[16] ? -$signed(mean_mag) : $signed(mean_mag);
      corr_q.defined    <= ok;
    end
  end

  assign valid_o = valid_q;
  assign corr_o  = corr_q;

endmodule

@@ hdl/rgb_image_correlation.sv @@
// ----------------------------------------------------------------------------
// rgb_image_correlation
// Per-channel Pearson correlation of a reference and a sample RGB image.
// ----------------------------------------------------------------------------
// Pixel pairs are taken one per cycle (start_i high, busy_o low) and folded
// into exact per-channel sums. The word flagged last_pixel is still summed,
// then busy_o rises for the closing computation: each channel lane runs eight
// 52-bit products on a shift-add multiplier, then a 15-step bitwise ratio
// search. The busy window is made up of a launch step, the multiplies, the
// search, a done step and a result step, and the result word shows for the
// last of these steps on corr_valid_o. The receiver cannot
// stall: the result word must be captured in that cycle. Results are Q1.14,
// truncated toward zero; defined is low (and all fields zero) on a zero
// variance or when more than 262144 pixels arrived. Sums clear per image.
module rgb_image_correlation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ric_pkg::pix_word_t  pixel_i,
  output logic                busy_o,
  output logic                corr_valid_o,
  output ric_pkg::corr_word_t corr_o
);
  import ric_pkg::*;

  logic            accept, acc_en;
  logic [CntW-1:0] count_q;
  logic            over_q, busy_q, go_q;
  logic [2:0]      done;
  lane_res_t       res_r, res_g, res_b;

  assign accept = start_i && !busy_q;
  assign acc_en = accept && (count_q < CntW'(MaxPixels));

  // Pixel count, overflow flag and busy window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      over_q  <= 1'b0;
      busy_q  <= 1'b0;
      go_q    <= 1'b0;
    end else begin
      go_q <= accept && pixel_i.last_pixel;
      if (accept && pixel_i.last_pixel) busy_q <= 1'b1;
      if (corr_valid_o) begin
        busy_q  <= 1'b0;
        count_q <= '0;
        over_q  <= 1'b0;
      end else if (acc_en) begin
        count_q <= count_q + 1'b1;
      end else if (accept) begin
        over_q <= 1'b1;
      end
    end
  end

  ric_lane u_lane_r (
    .clk_i, .rst_ni, .acc_en_i(acc_en), .x_i(pixel_i.ref_red),
    .y_i(pixel_i.sample_red), .n_i(count_q), .go_i(go_q),
    .done_o(done[0]), .res_o(res_r)
  );

  ric_lane u_lane_g (
    .clk_i, .rst_ni, .acc_en_i(acc_en), .x_i(pixel_i.ref_green),
    .y_i(pixel_i.sample_green), .n_i(count_q), .go_i(go_q),
    .done_o(done[1]), .res_o(res_g)
  );

  ric_lane u_lane_b (
    .clk_i, .rst_ni, .acc_en_i(acc_en), .x_i(pixel_i.ref_blue),
    .y_i(pixel_i.sample_blue), .n_i(count_q), .go_i(go_q),
    .done_o(done[2]), .res_o(res_b)
  );

  // Lanes run in lockstep, so all done flags rise together
  ric_merge u_merge (
    .clk_i, .rst_ni, .go_i(&done), .over_i(over_q),
    .red_i(res_r), .green_i(res_g), .blue_i(res_b),
    .valid_o(corr_valid_o), .corr_o
  );

  assign busy_o = busy_q;

endmodule

@@ hdl/ric_checker.sv @@
// ----------------------------------------------------------------------------
// ric_checker
// Port-level checks for the correlation block.
// ----------------------------------------------------------------------------
`include "rgb_image_correlation_macros.svh"

module ric_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input ric_pkg::pix_word_t  pixel_i,
  input logic                busy_o,
  input logic                corr_valid_o,
  input ric_pkg::corr_word_t corr_o
);
  import ric_pkg::*;

  logic last_acc, undef_res, zero_res;

  assign last_acc  = start_i && !busy_o && pixel_i.last_pixel;
  assign undef_res = corr_valid_o && !corr_o.defined;
  assign zero_res  = (corr_o.corr_red == '0) && (corr_o.corr_green == '0) &&
                     (corr_o.corr_blue == '0) && (corr_o.corr_mean == '0);

  `RIC_ASSERT_NXT(a_last_busy, last_acc, busy_o, "no busy after last")
  `RIC_ASSERT_NXT(a_pulse, corr_valid_o, !corr_valid_o, "result word longer than one cycle")
  `RIC_ASSERT_NXT(a_release, corr_valid_o, !busy_o, "busy held after result")
  `RIC_ASSERT_IMP(a_undef_zero, undef_res, zero_res, "undefined result not zero")

endmodule

bind rgb_image_correlation ric_checker u_ric_checker (.*);
